FILE: rtl/hslrgb_pkg.sv
`timescale 1ns / 1ps

package hslrgb_pkg;

   // fixed point: ONE stands for 1.0 on saturation, lightness and the outputs
   localparam int FRAC_BITS  = 16;
   localparam int ONE        = 1 << FRAC_BITS;
   localparam int HALF       = 1 << (FRAC_BITS - 1);

   // hue wheel: hue is scaled by six, so one sixth of a turn is SIXTH units
   localparam int HUE_BITS   = 16;
   localparam int SIXTH      = 1 << HUE_BITS;
   localparam int TURN       = 6 * SIXTH;
   localparam int HALF_U     = 1 << (HUE_BITS - 1);

   localparam int IN_W       = 18;             // signed Q2.16 inputs
   localparam int UNIT_W     = FRAC_BITS + 1;  // 0..ONE
   localparam int POS_W      = HUE_BITS + 3;   // 0..TURN-1
   localparam int SUM_W      = POS_W + 1;
   localparam int LS_W       = 2 * UNIT_W;     // l*s product
   localparam int WORK_W     = UNIT_W + 3;     // signed m1, m2, difference
   localparam int RAMP_W     = WORK_W + UNIT_W + 1;
   localparam int ALPHA_IN_W = 8;

   // pipeline stages
   localparam int NUM_STAGES = 5;
   localparam int ST_PREP    = 0;
   localparam int ST_MUL     = 1;
   localparam int ST_MIX     = 2;
   localparam int ST_RAMP    = 3;
   localparam int ST_OUT     = 4;

   typedef logic [UNIT_W-1:0]        unit_type;
   typedef logic [POS_W-1:0]         pos_type;
   typedef logic signed [WORK_W-1:0] work_type;

   typedef enum logic [1:0] {
      SEG_RISE = 2'd0,
      SEG_HIGH = 2'd1,
      SEG_FALL = 2'd2,
      SEG_LOW  = 2'd3
   } seg_type;

   typedef struct packed {
      seg_type  seg;
      unit_type x;
   } ramp_sel_type;

   typedef struct packed {
      logic [NUM_STAGES-1:0] load;
   } stage_ctrl_type;

   function automatic unit_type clamp_in(input logic signed [IN_W-1:0] v);
      unit_type r;
      if (v[IN_W-1]) begin
         r = '0;
      end else if (v[IN_W-2:0] > UNIT_W'(ONE)) begin
         r = UNIT_W'(ONE);
      end else begin
         r = v[IN_W-2:0];
      end
      return r;
   endfunction

   function automatic unit_type clamp_work(input work_type v);
      unit_type r;
      if (v < 0) begin
         r = '0;
      end else if (v > WORK_W'(ONE)) begin
         r = UNIT_W'(ONE);
      end else begin
         r = v[UNIT_W-1:0];
      end
      return r;
   endfunction

   // piecewise ramp: rising, flat high, falling, flat low
   function automatic ramp_sel_type decode_pos(input pos_type t);
      ramp_sel_type r;
      pos_type      fall;
      fall = POS_W'(4 * SIXTH) - t;
      r.x  = '0;
      if (t < POS_W'(SIXTH)) begin
         r.seg = SEG_RISE;
         r.x   = t[UNIT_W-1:0];
      end else if (t < POS_W'(3 * SIXTH)) begin
         r.seg = SEG_HIGH;
      end else if (t < POS_W'(4 * SIXTH)) begin
         r.seg = SEG_FALL;
         r.x   = fall[UNIT_W-1:0];
      end else begin
         r.seg = SEG_LOW;
      end
      return r;
   endfunction

   // round(a * 65536 / 255): 65536 = 255*257 + 1, so it is 257a plus one for a >= 128
   function automatic unit_type alpha_scale(input logic [ALPHA_IN_W-1:0] a);
      unit_type base;
      base = (UNIT_W'(a) << 8) + UNIT_W'(a);
      return base + UNIT_W'(a[ALPHA_IN_W-1]);
   endfunction

endpackage

FILE: rtl/hslrgb_front.sv
`timescale 1ns / 1ps

module hslrgb_front (
   input  logic                                 clock,
   input  hslrgb_pkg::stage_ctrl_type           ctrl,
   input  logic [hslrgb_pkg::HUE_BITS-1:0]      hue,
   input  logic signed [hslrgb_pkg::IN_W-1:0]   saturation,
   input  logic signed [hslrgb_pkg::IN_W-1:0]   lightness,
   input  logic [hslrgb_pkg::ALPHA_IN_W-1:0]    alpha_byte,
   output hslrgb_pkg::unit_type                 sat_q,
   output hslrgb_pkg::unit_type                 light_q,
   output logic [hslrgb_pkg::LS_W-1:0]          prod_q,
   output hslrgb_pkg::pos_type                  pos_r_q,
   output hslrgb_pkg::pos_type                  pos_g_q,
   output hslrgb_pkg::pos_type                  pos_b_q,
   output hslrgb_pkg::unit_type                 alpha_q
);
   import hslrgb_pkg::*;

   unit_type sat_in,  sat_ff,  sat2_ff;
   unit_type light_in, light_ff, light2_ff;
   pos_type  pos_g_in, pos_g_ff, pos_g2_ff;
   pos_type  pos_r_in, pos_r_ff, pos_r2_ff;
   pos_type  pos_b_in, pos_b_ff, pos_b2_ff;
   unit_type alpha_in, alpha_ff, alpha2_ff;
   logic [LS_W-1:0]  prod_in, prod_ff;
   logic [SUM_W-1:0] sum_r, sum_b;

   // stage 1: clamp, hue times six, the two shifted positions and alpha scaling
   always_comb begin
      sat_in   = clamp_in(saturation);
      light_in = clamp_in(lightness);
      pos_g_in = (POS_W'(hue) << 2) + (POS_W'(hue) << 1);
      sum_r    = SUM_W'(pos_g_in) + SUM_W'(2 * SIXTH);
      sum_b    = SUM_W'(pos_g_in) + SUM_W'(4 * SIXTH);
      if (sum_r >= SUM_W'(TURN)) begin
         sum_r = sum_r - SUM_W'(TURN);
      end
      if (sum_b >= SUM_W'(TURN)) begin
         sum_b = sum_b - SUM_W'(TURN);
      end
      pos_r_in = sum_r[POS_W-1:0];
      pos_b_in = sum_b[POS_W-1:0];
      alpha_in = alpha_scale(alpha_byte);
   end

   always_ff @(posedge clock) begin
      if (ctrl.load[ST_PREP]) begin
         sat_ff   <= sat_in;
         light_ff <= light_in;
         pos_g_ff <= pos_g_in;
         pos_r_ff <= pos_r_in;
         pos_b_ff <= pos_b_in;
         alpha_ff <= alpha_in;
      end
   end

   // stage 2: l*s
   assign prod_in = LS_W'(light_ff) * LS_W'(sat_ff);

   always_ff @(posedge clock) begin
      if (ctrl.load[ST_MUL]) begin
         prod_ff   <= prod_in;
         sat2_ff   <= sat_ff;
         light2_ff <= light_ff;
         pos_g2_ff <= pos_g_ff;
         pos_r2_ff <= pos_r_ff;
         pos_b2_ff <= pos_b_ff;
         alpha2_ff <= alpha_ff;
      end
   end

   assign sat_q   = sat2_ff;
   assign light_q = light2_ff;
   assign prod_q  = prod_ff;
   assign pos_r_q = pos_r2_ff;
   assign pos_g_q = pos_g2_ff;
   assign pos_b_q = pos_b2_ff;
   assign alpha_q = alpha2_ff;

endmodule

FILE: rtl/hslrgb_mix.sv
`timescale 1ns / 1ps

module hslrgb_mix (
   input  logic                          clock,
   input  hslrgb_pkg::stage_ctrl_type    ctrl,
   input  hslrgb_pkg::unit_type          sat,
   input  hslrgb_pkg::unit_type          light,
   input  logic [hslrgb_pkg::LS_W-1:0]   prod,
   input  hslrgb_pkg::pos_type           pos_r,
   input  hslrgb_pkg::pos_type           pos_g,
   input  hslrgb_pkg::pos_type           pos_b,
   input  hslrgb_pkg::unit_type          alpha,
   output hslrgb_pkg::work_type          m1_q,
   output hslrgb_pkg::work_type          m2_q,
   output hslrgb_pkg::ramp_sel_type      sel_r_q,
   output hslrgb_pkg::ramp_sel_type      sel_g_q,
   output hslrgb_pkg::ramp_sel_type      sel_b_q,
   output hslrgb_pkg::unit_type          alpha_q
);
   import hslrgb_pkg::*;

   logic [LS_W-1:0] ls_sum;
   work_type        ls_w, light_w, sat_w;
   work_type        m1_in, m1_ff, m2_in, m2_ff;
   ramp_sel_type    sel_r_ff, sel_g_ff, sel_b_ff;
   unit_type        alpha_ff;

   // stage 3: rounded l*s, then m2 and m1
   always_comb begin
      ls_sum  = prod + LS_W'(HALF);
      ls_w    = WORK_W'(ls_sum[LS_W-1:FRAC_BITS]);
      light_w = WORK_W'(light);
      sat_w   = WORK_W'(sat);
      if (light <= UNIT_W'(HALF)) begin
         m2_in = light_w + ls_w;
      end else begin
         m2_in = light_w + sat_w - ls_w;
      end
      m1_in = (light_w <<< 1) - m2_in;
   end

   always_ff @(posedge clock) begin
      if (ctrl.load[ST_MIX]) begin
         m1_ff    <= m1_in;
         m2_ff    <= m2_in;
         sel_r_ff <= decode_pos(pos_r);
         sel_g_ff <= decode_pos(pos_g);
         sel_b_ff <= decode_pos(pos_b);
         alpha_ff <= alpha;
      end
   end

   assign m1_q    = m1_ff;
   assign m2_q    = m2_ff;
   assign sel_r_q = sel_r_ff;
   assign sel_g_q = sel_g_ff;
   assign sel_b_q = sel_b_ff;
   assign alpha_q = alpha_ff;

endmodule

FILE: rtl/hslrgb_chan.sv
`timescale 1ns / 1ps

module hslrgb_chan (
   input  logic                          clock,
   input  hslrgb_pkg::stage_ctrl_type    ctrl,
   input  hslrgb_pkg::work_type          m1,
   input  hslrgb_pkg::work_type          m2,
   input  hslrgb_pkg::ramp_sel_type      sel,
   output hslrgb_pkg::unit_type          level
);
   import hslrgb_pkg::*;

   work_type                  diff;
   logic signed [RAMP_W-1:0]  prod_in, prod_ff;
   logic signed [RAMP_W:0]    rnd_sum, rnd;
   work_type                  m1_ff, m2_ff, ramp;
   seg_type                   seg_ff;
   unit_type                  level_in, level_ff;

   // stage 4: (m2 - m1) * offset
   always_comb begin
      diff    = m2 - m1;
      prod_in = diff * $signed({1'b0, sel.x});
   end

   always_ff @(posedge clock) begin
      if (ctrl.load[ST_RAMP]) begin
         prod_ff <= prod_in;
         m1_ff   <= m1;
         m2_ff   <= m2;
         seg_ff  <= sel.seg;
      end
   end

   // stage 5: round, add to m1, pick the piece and clamp
   always_comb begin
      rnd_sum = (RAMP_W + 1)'(prod_ff) + (RAMP_W + 1)'(HALF_U);
      rnd     = rnd_sum >>> HUE_BITS;
      ramp    = m1_ff + WORK_W'(rnd);
      case (seg_ff)
         SEG_RISE: level_in = clamp_work(ramp);
         SEG_HIGH: level_in = clamp_work(m2_ff);
         SEG_FALL: level_in = clamp_work(ramp);
         SEG_LOW:  level_in = clamp_work(m1_ff);
         default:  level_in = clamp_work(m1_ff);
      endcase
   end

   always_ff @(posedge clock) begin
      if (ctrl.load[ST_OUT]) begin
         level_ff <= level_in;
      end
   end

   assign level = level_ff;

endmodule

FILE: rtl/hsl_to_rgb_convert_unit.sv
`timescale 1ns / 1ps

// channel   | handshake            | payload
// ----------+----------------------+-------------------------------------------------
// req       | req_valid/req_ready  | req_hue, req_saturation, req_lightness, req_alpha_byte
// rsp       | rsp_valid/rsp_ready  | rsp_red, rsp_green, rsp_blue, rsp_alpha
//
// five register stages, one item per clock sustained while rsp_ready stays high; an item
// accepted passes through PREP, MUL, MIX, RAMP and OUT, and rsp_valid rises once it is in OUT
// the l*s multiply sits in a stage of its own; the three ramp multiplies share the RAMP stage
// reset is synchronous and clears only the stage valid bits
// a stalled rsp holds the output stage; earlier stages keep moving into empty
// slots, so req_ready drops only once every stage holds an item

module hsl_to_rgb_convert_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [hslrgb_pkg::HUE_BITS-1:0]     req_hue,
   input  logic signed [hslrgb_pkg::IN_W-1:0]  req_saturation,
   input  logic signed [hslrgb_pkg::IN_W-1:0]  req_lightness,
   input  logic [hslrgb_pkg::ALPHA_IN_W-1:0]   req_alpha_byte,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [hslrgb_pkg::UNIT_W-1:0]       rsp_red,
   output logic [hslrgb_pkg::UNIT_W-1:0]       rsp_green,
   output logic [hslrgb_pkg::UNIT_W-1:0]       rsp_blue,
   output logic [hslrgb_pkg::UNIT_W-1:0]       rsp_alpha
);
   import hslrgb_pkg::*;

   stage_ctrl_type        ctrl;
   logic [NUM_STAGES-1:0] valid_in, valid_ff;

   unit_type        sat_2, light_2, alpha_2, alpha_3;
   logic [LS_W-1:0] prod_2;
   pos_type         pos_r_2, pos_g_2, pos_b_2;
   work_type        m1_3, m2_3;
   ramp_sel_type    sel_r_3, sel_g_3, sel_b_3;
   unit_type        alpha4_ff, alpha5_ff;

   // a stage loads when it is empty or the stage after it loads too
   always_comb begin
      ctrl.load[ST_OUT] = !valid_ff[ST_OUT] || rsp_ready;
      for (int i = NUM_STAGES - 2; i >= 0; i--) begin
         ctrl.load[i] = !valid_ff[i] || ctrl.load[i+1];
      end
   end

   always_comb begin
      valid_in[ST_PREP] = ctrl.load[ST_PREP] ? req_valid : valid_ff[ST_PREP];
      for (int i = 1; i < NUM_STAGES; i++) begin
         valid_in[i] = ctrl.load[i] ? valid_ff[i-1] : valid_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_ready = ctrl.load[ST_PREP];
   assign rsp_valid = valid_ff[ST_OUT];

   // clamp, hue positions, l*s
   hslrgb_front u_front (
      .clock      (clock),
      .ctrl       (ctrl),
      .hue        (req_hue),
      .saturation (req_saturation),
      .lightness  (req_lightness),
      .alpha_byte (req_alpha_byte),
      .sat_q      (sat_2),
      .light_q    (light_2),
      .prod_q     (prod_2),
      .pos_r_q    (pos_r_2),
      .pos_g_q    (pos_g_2),
      .pos_b_q    (pos_b_2),
      .alpha_q    (alpha_2)
   );

   // m1, m2 and the ramp piece of each channel
   hslrgb_mix u_mix (
      .clock   (clock),
      .ctrl    (ctrl),
      .sat     (sat_2),
      .light   (light_2),
      .prod    (prod_2),
      .pos_r   (pos_r_2),
      .pos_g   (pos_g_2),
      .pos_b   (pos_b_2),
      .alpha   (alpha_2),
      .m1_q    (m1_3),
      .m2_q    (m2_3),
      .sel_r_q (sel_r_3),
      .sel_g_q (sel_g_3),
      .sel_b_q (sel_b_3),
      .alpha_q (alpha_3)
   );

   // one ramp per color channel
   hslrgb_chan u_chan_red (
      .clock (clock),
      .ctrl  (ctrl),
      .m1    (m1_3),
      .m2    (m2_3),
      .sel   (sel_r_3),
      .level (rsp_red)
   );

   hslrgb_chan u_chan_green (
      .clock (clock),
      .ctrl  (ctrl),
      .m1    (m1_3),
      .m2    (m2_3),
      .sel   (sel_g_3),
      .level (rsp_green)
   );

   hslrgb_chan u_chan_blue (
      .clock (clock),
      .ctrl  (ctrl),
      .m1    (m1_3),
      .m2    (m2_3),
      .sel   (sel_b_3),
      .level (rsp_blue)
   );

   // alpha is done early and just rides along
   always_ff @(posedge clock) begin
      if (ctrl.load[ST_RAMP]) begin
         alpha4_ff <= alpha_3;
      end
      if (ctrl.load[ST_OUT]) begin
         alpha5_ff <= alpha4_ff;
      end
   end

   assign rsp_alpha = alpha5_ff;

endmodule

FILE: rtl/hslrgb_checker.sv
`timescale 1ns / 1ps

module hslrgb_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_ready,
   input  logic [hslrgb_pkg::HUE_BITS-1:0]     req_hue,
   input  logic signed [hslrgb_pkg::IN_W-1:0]  req_saturation,
   input  logic signed [hslrgb_pkg::IN_W-1:0]  req_lightness,
   input  logic [hslrgb_pkg::ALPHA_IN_W-1:0]   req_alpha_byte,
   input  logic                                rsp_valid,
   input  logic                                rsp_ready,
   input  logic [hslrgb_pkg::UNIT_W-1:0]       rsp_red,
   input  logic [hslrgb_pkg::UNIT_W-1:0]       rsp_green,
   input  logic [hslrgb_pkg::UNIT_W-1:0]       rsp_blue,
   input  logic [hslrgb_pkg::UNIT_W-1:0]       rsp_alpha
);
   import hslrgb_pkg::*;

   logic unused_in;
   assign unused_in = ^{req_valid, req_hue, req_saturation, req_lightness, req_alpha_byte};

   // a stalled result item holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_red) && $stable(rsp_green)
         && $stable(rsp_blue) && $stable(rsp_alpha))
      else $error("rsp item changed while stalled");

   // reset empties the pipeline
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid after reset");

   // a taking consumer never backs up the input
   a_ready_flow: assert property (@(posedge clock) disable iff (reset)
      rsp_ready |-> req_ready)
      else $error("req_ready low while rsp_ready high");

   // every output stays within 0..1.0
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_red <= UNIT_W'(ONE) && rsp_green <= UNIT_W'(ONE)
         && rsp_blue <= UNIT_W'(ONE) && rsp_alpha <= UNIT_W'(ONE))
      else $error("rsp channel above one");

endmodule

bind hsl_to_rgb_convert_unit hslrgb_checker u_checker (.*);

FILE: verif/tb.sv
`timescale 1ns / 1ps

module tb;
   import hslrgb_pkg::*;

   typedef struct {
      logic [HUE_BITS-1:0]     hue;
      logic signed [IN_W-1:0]  sat;
      logic signed [IN_W-1:0]  light;
      logic [ALPHA_IN_W-1:0]   alpha_byte;
   } hsl_color_type;

   typedef struct {
      unit_type red;
      unit_type green;
      unit_type blue;
      unit_type alpha;
   } rgba_pixel_type;

   // holds the expected pixels in order and compares them against the converter output
   class rgba_scoreboard;
      rgba_pixel_type pixel_q[$];
      int             error_count = 0;
      int             shown_count = 0;

      function longint clamp_to_unit(input longint v);
         if (v < 0) begin
            return 0;
         end
         if (v > ONE) begin
            return ONE;
         end
         return v;
      endfunction

      // piecewise hue ramp, t in sixth-turn units of SIXTH
      function longint hue_ramp_level(input longint t, input longint m1, input longint m2);
         longint d;
         d = m2 - m1;
         if (t < SIXTH) begin
            return m1 + ((d * t + HALF_U) >>> HUE_BITS);
         end
         if (t < 3 * SIXTH) begin
            return m2;
         end
         if (t < 4 * SIXTH) begin
            return m1 + ((d * (4 * SIXTH - t) + HALF_U) >>> HUE_BITS);
         end
         return m1;
      endfunction

      function rgba_pixel_type convert_hsl(input hsl_color_type c);
         rgba_pixel_type p;
         longint         s, l, ls, m1, m2, t, tr, tb, a;
         s  = clamp_to_unit(longint'(c.sat));
         l  = clamp_to_unit(longint'(c.light));
         ls = (l * s + HALF) >>> FRAC_BITS;
         m2 = (2 * l <= ONE) ? (l + ls) : (l + s - ls);
         m1 = 2 * l - m2;
         t  = longint'(c.hue) * 6;
         tr = (t + 2 * SIXTH) % TURN;
         tb = (t + TURN - 2 * SIXTH) % TURN;
         a  = longint'(c.alpha_byte);
         p.red   = UNIT_W'(clamp_to_unit(hue_ramp_level(tr, m1, m2)));
         p.green = UNIT_W'(clamp_to_unit(hue_ramp_level(t, m1, m2)));
         p.blue  = UNIT_W'(clamp_to_unit(hue_ramp_level(tb, m1, m2)));
         p.alpha = UNIT_W'((2 * a * ONE + 255) / 510);
         return p;
      endfunction

      function void note_color(input hsl_color_type c);
         pixel_q.push_back(convert_hsl(c));
      endfunction

      function int pending();
         return pixel_q.size();
      endfunction

      function void check_pixel(input rgba_pixel_type got);
         rgba_pixel_type want;
         if (pixel_q.size() == 0) begin
            error_count++;
            if (shown_count < 10) begin
               shown_count++;
               $display("unexpected pixel r=%0d g=%0d b=%0d a=%0d",
                        got.red, got.green, got.blue, got.alpha);
            end
            return;
         end
         want = pixel_q.pop_front();
         if (got.red !== want.red || got.green !== want.green ||
             got.blue !== want.blue || got.alpha !== want.alpha) begin
            error_count++;
            if (shown_count < 10) begin
               shown_count++;
               $display("pixel mismatch: exp r=%0d g=%0d b=%0d a=%0d, got r=%0d g=%0d b=%0d a=%0d",
                        want.red, want.green, want.blue, want.alpha,
                        got.red, got.green, got.blue, got.alpha);
            end
         end
      endfunction

      function void check_drained();
         if (pixel_q.size() != 0) begin
            error_count++;
            if (shown_count < 10) begin
               shown_count++;
               $display("%0d expected pixels never arrived", pixel_q.size());
            end
         end
      endfunction
   endclass

   localparam int RESET_CYCLES = 6;
   localparam int STALL_LIMIT  = 4000;   // cycles with no item moving on either side
   localparam int DRAIN_CYCLES = 20;     // pipeline is five deep

   logic                    clock;
   logic                    reset;
   logic                    req_valid;
   logic                    req_ready;
   logic [HUE_BITS-1:0]     req_hue;
   logic signed [IN_W-1:0]  req_saturation;
   logic signed [IN_W-1:0]  req_lightness;
   logic [ALPHA_IN_W-1:0]   req_alpha_byte;
   logic                    rsp_valid;
   logic                    rsp_ready;
   logic [UNIT_W-1:0]       rsp_red;
   logic [UNIT_W-1:0]       rsp_green;
   logic [UNIT_W-1:0]       rsp_blue;
   logic [UNIT_W-1:0]       rsp_alpha;

   rgba_scoreboard pixel_sb;
   int             req_idle_pct;
   int             rsp_idle_pct;
   hsl_color_type  directed_q[$];

   hsl_to_rgb_convert_unit u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_hue        (req_hue),
      .req_saturation (req_saturation),
      .req_lightness  (req_lightness),
      .req_alpha_byte (req_alpha_byte),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_red        (rsp_red),
      .rsp_green      (rsp_green),
      .rsp_blue       (rsp_blue),
      .rsp_alpha      (rsp_alpha)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic hsl_color_type make_color(input int h, input int s, input int l,
                                                input int a);
      hsl_color_type c;
      c.hue        = HUE_BITS'(h);
      c.sat        = IN_W'(s);
      c.light      = IN_W'(l);
      c.alpha_byte = ALPHA_IN_W'(a);
      return c;
   endfunction

   // saturation / lightness mix: mostly in range, with negatives, overflows and corners
   function automatic logic signed [IN_W-1:0] random_unit_input();
      logic signed [IN_W-1:0] v;
      int                     pick;
      int                     corner [7] = '{0, 1, 32767, 32768, 32769, 65535, 65536};
      pick = $urandom_range(0, 9);
      if (pick <= 5) begin
         v = IN_W'($urandom_range(0, ONE));
      end else if (pick == 6) begin
         v = IN_W'($urandom());
      end else if (pick == 7) begin
         v = IN_W'($urandom_range(0, 131071)) | 18'h20000;
      end else if (pick == 8) begin
         v = IN_W'($urandom_range(ONE + 1, 131071));
      end else begin
         v = IN_W'(corner[$urandom_range(0, 6)]);
      end
      return v;
   endfunction

   function automatic hsl_color_type random_color();
      hsl_color_type c;
      int            edge_hue [8] = '{0, 10922, 21845, 32768, 43690, 54613, 65534, 65535};
      if ($urandom_range(0, 9) == 0) begin
         // land on or beside a segment edge
         c.hue = HUE_BITS'(edge_hue[$urandom_range(0, 7)] + $urandom_range(0, 1));
      end else begin
         c.hue = HUE_BITS'($urandom_range(0, 65535));
      end
      c.sat        = random_unit_input();
      c.light      = random_unit_input();
      c.alpha_byte = ALPHA_IN_W'($urandom_range(0, 255));
      return c;
   endfunction

   // present one item, wait for acceptance and record the expected pixel
   task automatic send_color(input hsl_color_type c);
      while ($urandom_range(0, 99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_hue        <= c.hue;
      req_saturation <= c.sat;
      req_lightness  <= c.light;
      req_alpha_byte <= c.alpha_byte;
      @(posedge clock);
      while (!req_ready) begin
         @(posedge clock);
      end
      pixel_sb.note_color(c);
   endtask

   // sender holds off until the pipeline has handed back every pixel
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      while (pixel_sb.pending() != 0) begin
         @(posedge clock);
      end
   endtask

   // result side: check on every accepted item, then roll the next ready
   initial begin
      rgba_pixel_type got;
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            got.red   = rsp_red;
            got.green = rsp_green;
            got.blue  = rsp_blue;
            got.alpha = rsp_alpha;
            pixel_sb.check_pixel(got);
         end
         rsp_ready <= ($urandom_range(0, 99) >= rsp_idle_pct);
      end
   end

   // watchdog: ends the run if nothing moves on either channel for too long
   initial begin
      int still_cycles;
      still_cycles = 0;
      while (still_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            still_cycles = 0;
         end else begin
            still_cycles++;
         end
      end
      $display("** hsl_to_rgb_convert_unit: FAILED **");
      $finish;
   end

   initial begin
      pixel_sb       = new();
      req_idle_pct   = 27;
      rsp_idle_pct   = 27;
      reset          <= 1'b1;
      req_valid      <= 1'b0;
      req_hue        <= '0;
      req_saturation <= '0;
      req_lightness  <= '0;
      req_alpha_byte <= '0;

      // directed: field extremes, hue segment edges, clamping, lightness at one half
      directed_q.push_back(make_color(0, 0, 0, 0));
      directed_q.push_back(make_color(65535, 65536, 32768, 255));
      directed_q.push_back(make_color(0, 65536, 32768, 128));
      directed_q.push_back(make_color(32768, 65536, 32768, 127));
      directed_q.push_back(make_color(32767, 65536, 32768, 126));
      directed_q.push_back(make_color(10922, 65536, 32768, 1));
      directed_q.push_back(make_color(10923, 65536, 32768, 2));
      directed_q.push_back(make_color(21845, 65536, 32768, 3));
      directed_q.push_back(make_color(21846, 65536, 32768, 4));
      directed_q.push_back(make_color(43690, 65536, 32768, 5));
      directed_q.push_back(make_color(43691, 65536, 32768, 6));
      directed_q.push_back(make_color(54613, 65536, 32768, 7));
      directed_q.push_back(make_color(54614, 65536, 32768, 8));
      directed_q.push_back(make_color(1000, -131072, 131071, 254));
      directed_q.push_back(make_color(20000, 131071, -131072, 64));
      directed_q.push_back(make_color(30000, -1, 65537, 200));
      directed_q.push_back(make_color(40000, 65537, -1, 100));
      directed_q.push_back(make_color(50000, 32768, 32767, 9));
      directed_q.push_back(make_color(5000, 32768, 32769, 77));
      directed_q.push_back(make_color(60000, 1, 1, 255));
      directed_q.push_back(make_color(12345, 65535, 65535, 129));
      directed_q.push_back(make_color(0, 65536, 65536, 0));
      directed_q.push_back(make_color(43691, 45000, 20000, 253));
      directed_q.push_back(make_color(65535, 131071, 131071, 255));

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_q[i]) begin
         send_color(directed_q[i]);
      end
      wait_for_drain();

      // random, with idling on both sides
      repeat (650) send_color(random_color());
      wait_for_drain();

      // long stretch at full rate on both channels
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      repeat (450) send_color(random_color());

      req_idle_pct = 27;
      rsp_idle_pct = 27;
      repeat (600) send_color(random_color());
      req_valid <= 1'b0;

      while (pixel_sb.pending() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      pixel_sb.check_drained();

      if (pixel_sb.error_count == 0) begin
         $display("** hsl_to_rgb_convert_unit: PASSED **");
      end else begin
         $display("** hsl_to_rgb_convert_unit: FAILED **");
      end
      $finish;
   end

endmodule

FILE: files.f
rtl/hslrgb_pkg.sv
rtl/hslrgb_front.sv
rtl/hslrgb_mix.sv
rtl/hslrgb_chan.sv
rtl/hsl_to_rgb_convert_unit.sv
rtl/hslrgb_checker.sv
verif/tb.sv
